// File: hdl/assert_macros.svh
// Shared assertion macros for the cache tag store.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SALC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("salc assertion failed");

// Check that cons holds in the cycle after ante.
`define SALC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("salc assertion failed");

`endif

// File: hdl/salc_pkg.sv
`default_nettype none

package salc_pkg;

  // Default geometry.
  localparam int unsigned DEF_SETS       = 256;
  localparam int unsigned DEF_WAYS       = 8;
  localparam int unsigned DEF_ADDR_WIDTH = 48;

  // Port field widths.
  localparam int unsigned OP_W       = 2;
  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned OUTC_W     = 2;
  localparam int unsigned SET_OUT_W  = 8;
  localparam int unsigned WAY_OUT_W  = 3;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned SETB_W     = 4;
  localparam int unsigned BLKB_W     = 5;
  localparam int unsigned WAYSCFG_W  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 5;
  // Raw set index before folding: up to 15 set bits.
  localparam int unsigned SIDX_W     = 15;

  // Access kinds.
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

  // Lookup outcomes.
  localparam logic [OUTC_W-1:0] OUT_HIT   = 2'd0;
  localparam logic [OUTC_W-1:0] OUT_FILL  = 2'd1;
  localparam logic [OUTC_W-1:0] OUT_EVICT = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  // Configuration reset values.
  localparam logic [SETB_W-1:0]    RST_SET_BITS   = 4'd4;
  localparam logic [BLKB_W-1:0]    RST_BLOCK_BITS = 5'd4;
  localparam logic [WAYSCFG_W-1:0] RST_WAYS       = 4'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr;      // write one zero row of the clearing pass
    logic capture;  // latch the request
    logic fold;     // reduce the raw set index
    logic rd;       // read the set row
    logic look;     // compare tags, pick the way
    logic commit;   // write the row back, update totals, present result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_ok;   // the offered request carries a valid access kind
    logic clr_last; // clearing pass is at its last row
  } status_t;

endpackage

`default_nettype wire

// File: hdl/set_associative_lru_cache_core.sv
// The result strobe done_o is registered from the write-back step of a request.
// A request is taken, folded, read, compared and written back before another is taken.
// An unused access kind is dropped at once: no result, busy_o stays low.
// Reset is asynchronous, active low; a clearing pass then zeroes SETS rows, one a
// cycle, with busy_o high. done_o is high for one cycle only: the receiver cannot stall.
`default_nettype none

module set_associative_lru_cache_core #(
  parameter int unsigned SETS       = salc_pkg::DEF_SETS,
  parameter int unsigned WAYS       = salc_pkg::DEF_WAYS,
  parameter int unsigned ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // Request side.
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [salc_pkg::OP_W-1:0]       op_i,
  input  wire logic [salc_pkg::ADDR_W-1:0]     address_i,
  // Result side.
  output logic                                 done_o,
  output logic [salc_pkg::OUTC_W-1:0]          outcome_o,
  output logic                                 second_hit_o,
  output logic [salc_pkg::SET_OUT_W-1:0]       set_index_o,
  output logic [salc_pkg::WAY_OUT_W-1:0]       way_used_o,
  output logic [salc_pkg::TOTAL_W-1:0]         hit_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]         miss_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]         evict_total_o
);

  // One memory row holds a whole set: valid bits, LRU ranks (0 is most recent)
  // and tags of every way, so each lookup is a single read and a single write.
  localparam int unsigned SetW  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned RankW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned TagW  = (ADDR_WIDTH < salc_pkg::ADDR_W) ? ADDR_WIDTH
                                                                 : salc_pkg::ADDR_W;
  localparam int unsigned RowW  = WAYS * (1 + RankW + TagW);

  salc_pkg::cmd_t    cmd;
  salc_pkg::status_t status;

  logic            ram_we;
  logic [SetW-1:0] ram_waddr;
  logic [RowW-1:0] ram_wdata;
  logic            ram_re;
  logic [SetW-1:0] ram_raddr;
  logic [RowW-1:0] ram_rdata;

  // Sequence the clearing pass and the steps of each request.
  salc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Address split, set fold, tag compare, LRU update, totals and result register.
  salc_dp #(
    .SETS       (SETS),
    .WAYS       (WAYS),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .op_i          (op_i),
    .address_i     (address_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .done_o        (done_o),
    .outcome_o     (outcome_o),
    .second_hit_o  (second_hit_o),
    .set_index_o   (set_index_o),
    .way_used_o    (way_used_o),
    .hit_total_o   (hit_total_o),
    .miss_total_o  (miss_total_o),
    .evict_total_o (evict_total_o)
  );

  // Set store: one row per set, registered read.
  salc_ram #(
    .Width (RowW),
    .Depth (SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

// File: hdl/salc_ram.sv
`default_nettype none

module salc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/salc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module salc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire salc_pkg::status_t status_i,
  output salc_pkg::cmd_t         cmd_o,
  output logic                   busy_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_READ  = 3'd3;
  localparam logic [2:0] ST_LOOK  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Drop requests with an unused access kind.
        if (start_i && status_i.req_ok) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  `SALC_ASSERT_NOW(a_cmd_onehot, 1'b1,
    $onehot0({cmd_o.clr, cmd_o.capture, cmd_o.fold, cmd_o.rd, cmd_o.look, cmd_o.commit}))
  `SALC_ASSERT_NEXT(a_capture_busy, cmd_o.capture, busy_o && !cmd_o.commit)

endmodule

`default_nettype wire

// File: hdl/salc_dp.sv
`default_nettype none
`include "assert_macros.svh"

module salc_dp #(
  parameter int unsigned SETS       = salc_pkg::DEF_SETS,
  parameter int unsigned WAYS       = salc_pkg::DEF_WAYS,
  parameter int unsigned ADDR_WIDTH = salc_pkg::DEF_ADDR_WIDTH,
  localparam int unsigned SetW  = (SETS > 1) ? $clog2(SETS) : 1,
  localparam int unsigned RankW = (WAYS > 1) ? $clog2(WAYS) : 1,
  localparam int unsigned TagW  = (ADDR_WIDTH < salc_pkg::ADDR_W) ? ADDR_WIDTH
                                                                 : salc_pkg::ADDR_W,
  localparam int unsigned RowW  = WAYS * (1 + RankW + TagW)
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire salc_pkg::cmd_t                      cmd_i,
  output salc_pkg::status_t                        status_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [salc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  wire logic [salc_pkg::OP_W-1:0]           op_i,
  input  wire logic [salc_pkg::ADDR_W-1:0]         address_i,
  output logic                                     ram_we_o,
  output logic [SetW-1:0]                          ram_waddr_o,
  output logic [RowW-1:0]                          ram_wdata_o,
  output logic                                     ram_re_o,
  output logic [SetW-1:0]                          ram_raddr_o,
  input  wire logic [RowW-1:0]                     ram_rdata_i,
  output logic                                     done_o,
  output logic [salc_pkg::OUTC_W-1:0]              outcome_o,
  output logic                                     second_hit_o,
  output logic [salc_pkg::SET_OUT_W-1:0]           set_index_o,
  output logic [salc_pkg::WAY_OUT_W-1:0]           way_used_o,
  output logic [salc_pkg::TOTAL_W-1:0]             hit_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]             miss_total_o,
  output logic [salc_pkg::TOTAL_W-1:0]             evict_total_o
);

  localparam int unsigned AW      = salc_pkg::ADDR_W;
  localparam int unsigned TW      = salc_pkg::TOTAL_W;
  localparam int unsigned RankOfs = WAYS;
  localparam int unsigned TagOfs  = WAYS + WAYS * RankW;
  localparam logic [AW-1:0] AddrMask = (TagW >= AW) ? {AW{1'b1}}
                                                    : ((AW'(1) << TagW) - AW'(1));
  localparam logic [SetW-1:0]  LastSet = SetW'(SETS - 1);
  localparam logic [RankW-1:0] MaxRank = RankW'(WAYS - 1);
  localparam logic [5:0]       WaysMax = 6'(WAYS);
  localparam bit               SetsPow2 = ((SETS & (SETS - 1)) == 0);

  // Configuration registers.
  logic [salc_pkg::SETB_W-1:0]    set_bits_q;
  logic [salc_pkg::BLKB_W-1:0]    block_bits_q;
  logic [salc_pkg::WAYSCFG_W-1:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= salc_pkg::RST_SET_BITS;
      block_bits_q <= salc_pkg::RST_BLOCK_BITS;
      ways_q       <= salc_pkg::RST_WAYS;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        salc_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[salc_pkg::SETB_W-1:0];
        salc_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i;
        salc_pkg::CFG_WAYS:       ways_q       <= cfg_wdata_i[salc_pkg::WAYSCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing pass row counter.
  logic [SetW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + SetW'(1);
    end
  end

  assign status_o.clr_last = (clr_cnt_q == LastSet);
  assign status_o.req_ok   = (op_i != salc_pkg::OP_NONE);

  // Request capture: split the address, work out the active ways.
  localparam int unsigned SIDX_LOCAL_W = salc_pkg::SIDX_W;

  logic [salc_pkg::OP_W-1:0] op_q;
  logic [SIDX_LOCAL_W-1:0]   raw_q;
  logic [TagW-1:0]           tag_q;
  logic [WAYS-1:0]           act_q;

  logic [AW-1:0]          addr_m;
  logic [AW-1:0]          addr_sh;
  logic [AW-1:0]          tag_sh;
  logic [15:0]            idx_mask;
  logic [5:0]             tag_shift;
  logic [5:0]             ways6;
  logic [5:0]             nw6;
  logic [WAYS-1:0]        act_c;

  always_comb begin
    addr_m    = address_i & AddrMask;
    addr_sh   = addr_m >> block_bits_q;
    idx_mask  = ~(16'hFFFF << set_bits_q);
    tag_shift = {2'b00, set_bits_q} + {1'b0, block_bits_q};
    tag_sh    = addr_m >> tag_shift;
    ways6     = {2'b00, ways_q};
    if (ways6 == 6'd0) begin
      nw6 = 6'd1;
    end else if (ways6 > WaysMax) begin
      nw6 = WaysMax;
    end else begin
      nw6 = ways6;
    end
    for (int j = 0; j < WAYS; j++) begin
      act_c[j] = (6'(j) < nw6);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      raw_q <= addr_sh[SIDX_LOCAL_W-1:0] & idx_mask[SIDX_LOCAL_W-1:0];
      tag_q <= tag_sh[TagW-1:0];
      act_q <= act_c;
    end
  end

  // Fold the raw index onto the set count.
  logic [SetW-1:0] set_c;

  if (SetsPow2) begin : g_fold_mask
    localparam int unsigned ExtW = SetW + SIDX_LOCAL_W;
    logic [SetW-1:0] red_q;
    logic [ExtW-1:0] raw_ext;

    assign raw_ext = ExtW'(raw_q);

    always_ff @(posedge clk_i) begin
      if (cmd_i.fold) begin
        red_q <= raw_ext[SetW-1:0] & LastSet;
      end
    end

    assign set_c = red_q;
  end else begin : g_fold_recip
    // Quotient by reciprocal; exact for a 15-bit dividend with 32 fraction bits.
    localparam int unsigned PW = SIDX_LOCAL_W + 33;
    localparam logic [32:0] Recip = 33'(((64'd1 << 32) + 64'(SETS) - 64'd1) / 64'(SETS));
    localparam logic [32:0] SetsV = 33'(SETS);
    logic [PW-1:0] prod_q;
    logic [32:0]   quot;
    logic [32:0]   qs;
    logic [32:0]   rem;

    always_ff @(posedge clk_i) begin
      if (cmd_i.fold) begin
        prod_q <= PW'(raw_q) * PW'(Recip);
      end
    end

    assign quot  = 33'(prod_q[PW-1:32]);
    assign qs    = quot * SetsV;
    assign rem   = 33'(raw_q) - qs;
    assign set_c = rem[SetW-1:0];
  end

  logic [SetW-1:0] set_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      set_q <= set_c;
    end
  end

  // Lookup on the registered row.
  logic [WAYS-1:0]  row_valid;
  logic [RankW-1:0] row_rank [WAYS];
  logic [TagW-1:0]  row_tag  [WAYS];

  always_comb begin
    for (int j = 0; j < WAYS; j++) begin
      row_valid[j] = ram_rdata_i[j];
      row_rank[j]  = ram_rdata_i[RankOfs + j*RankW +: RankW];
      row_tag[j]   = ram_rdata_i[TagOfs + j*TagW +: TagW];
    end
  end

  localparam int unsigned WayW = (WAYS > 1) ? $clog2(WAYS) : 1;

  logic                       hit_c, inv_c;
  logic [WayW-1:0]            hit_way, inv_way, vic_way;
  logic [RankW-1:0]           hit_rank, best;
  logic [salc_pkg::OUTC_W-1:0] outcome_c;
  logic [WayW-1:0]            way_c;
  logic [RankW-1:0]           limit_c;

  always_comb begin
    hit_c    = 1'b0;
    inv_c    = 1'b0;
    hit_way  = '0;
    inv_way  = '0;
    hit_rank = '0;
    vic_way  = '0;
    best     = '0;
    // Scan downwards so the lowest-numbered way wins.
    for (int j = WAYS - 1; j >= 0; j--) begin
      if (act_q[j] && row_valid[j] && (row_tag[j] == tag_q)) begin
        hit_c    = 1'b1;
        hit_way  = WayW'(j);
        hit_rank = row_rank[j];
      end
      if (act_q[j] && !row_valid[j]) begin
        inv_c   = 1'b1;
        inv_way = WayW'(j);
      end
    end
    // Victim: lowest-numbered way holding the largest rank.
    for (int j = 0; j < WAYS; j++) begin
      if (act_q[j] && ((j == 0) || (row_rank[j] > best))) begin
        best    = row_rank[j];
        vic_way = WayW'(j);
      end
    end
    if (hit_c) begin
      outcome_c = salc_pkg::OUT_HIT;
      way_c     = hit_way;
      limit_c   = hit_rank;
    end else if (inv_c) begin
      outcome_c = salc_pkg::OUT_FILL;
      way_c     = inv_way;
      limit_c   = best;
    end else begin
      outcome_c = salc_pkg::OUT_EVICT;
      way_c     = vic_way;
      limit_c   = best;
    end
  end

  logic [salc_pkg::OUTC_W-1:0] look_out_q;
  logic [WayW-1:0]             way_q;
  logic [RankW-1:0]            limit_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      look_out_q <= outcome_c;
      way_q      <= way_c;
      limit_q    <= limit_c;
    end
  end

  // Row update: promote the chosen way, age those below the limit (every valid way on a fill).
  logic [RowW-1:0] new_row;
  logic            no_limit;
  logic            is_miss;

  always_comb begin
    no_limit = (look_out_q == salc_pkg::OUT_FILL);
    is_miss  = (look_out_q != salc_pkg::OUT_HIT);
    new_row  = ram_rdata_i;
    for (int j = 0; j < WAYS; j++) begin
      if (WayW'(j) == way_q) begin
        new_row[j]                          = 1'b1;
        new_row[RankOfs + j*RankW +: RankW] = '0;
        if (is_miss) begin
          new_row[TagOfs + j*TagW +: TagW] = tag_q;
        end
      end else if (act_q[j] && row_valid[j] && (no_limit || (row_rank[j] < limit_q)) &&
                   (row_rank[j] < MaxRank)) begin
        new_row[RankOfs + j*RankW +: RankW] = row_rank[j] + RankW'(1);
      end
    end
  end

  assign ram_we_o    = cmd_i.clr | cmd_i.commit;
  assign ram_waddr_o = cmd_i.clr ? clr_cnt_q : set_q;
  assign ram_wdata_o = cmd_i.clr ? '0 : new_row;
  assign ram_re_o    = cmd_i.rd;
  assign ram_raddr_o = set_c;

  // Running totals, saturating.
  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] v, input logic [1:0] inc);
    logic [TW:0] sum;
    sum = {1'b0, v} + (TW+1)'(inc);
    return sum[TW] ? {TW{1'b1}} : sum[TW-1:0];
  endfunction

  logic [TW-1:0] hit_total_q, miss_total_q, evict_total_q;
  logic [TW-1:0] hit_total_d, miss_total_d, evict_total_d;
  logic [1:0]    hit_inc;
  logic          is_mod;

  always_comb begin
    is_mod        = (op_q == salc_pkg::OP_MODIFY);
    hit_inc       = {1'b0, !is_miss} + {1'b0, is_mod};
    hit_total_d   = sat_add(hit_total_q, hit_inc);
    miss_total_d  = sat_add(miss_total_q, {1'b0, is_miss});
    evict_total_d = sat_add(evict_total_q,
                            {1'b0, (look_out_q == salc_pkg::OUT_EVICT)});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_total_q   <= '0;
      miss_total_q  <= '0;
      evict_total_q <= '0;
      done_o        <= 1'b0;
    end else begin
      done_o <= cmd_i.commit;
      if (cmd_i.commit) begin
        hit_total_q   <= hit_total_d;
        miss_total_q  <= miss_total_d;
        evict_total_q <= evict_total_d;
      end
    end
  end

  // Result register.
  logic [SetW+salc_pkg::SET_OUT_W-1:0] set_ext;
  logic [WayW+salc_pkg::WAY_OUT_W-1:0] way_ext;

  assign set_ext = (SetW + salc_pkg::SET_OUT_W)'(set_q);
  assign way_ext = (WayW + salc_pkg::WAY_OUT_W)'(way_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      outcome_o    <= look_out_q;
      second_hit_o <= is_mod;
      set_index_o  <= set_ext[salc_pkg::SET_OUT_W-1:0];
      way_used_o   <= way_ext[salc_pkg::WAY_OUT_W-1:0];
    end
  end

  assign hit_total_o   = hit_total_q;
  assign miss_total_o  = miss_total_q;
  assign evict_total_o = evict_total_q;

  `SALC_ASSERT_NOW(a_evict_le_miss, 1'b1, evict_total_q <= miss_total_q)
  `SALC_ASSERT_NEXT(a_hits_monotonic, 1'b1, hit_total_q >= $past(hit_total_q))
  `SALC_ASSERT_NEXT(a_done_after_commit, cmd_i.commit, done_o)

endmodule

`default_nettype wire
